// ===== design/drpk_pkg.sv =====
// shared types, constants and lookup functions for the der rsa public key parser
// no dependencies; imported by drpk_step and der_rsa_public_key_parser
package drpk_pkg;

	localparam int MAX_LEN_BYTES = 8;
	localparam int LEN_W         = 8 * MAX_LEN_BYTES;
	localparam int LEN_CNT_W     = $clog2(MAX_LEN_BYTES + 1);

	// status codes
	localparam logic [2:0] ST_BUSY  = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_EARLY = 3'd2;
	localparam logic [2:0] ST_TAG   = 3'd3;
	localparam logic [2:0] ST_LEN   = 3'd4;
	localparam logic [2:0] ST_OID   = 3'd5;
	localparam logic [2:0] ST_NULL  = 3'd6;
	localparam logic [2:0] ST_BITS  = 3'd7;

	// elements of the fixed layout
	localparam logic [2:0] EL_OUTER  = 3'd0;
	localparam logic [2:0] EL_INNER  = 3'd1;
	localparam logic [2:0] EL_OID    = 3'd2;
	localparam logic [2:0] EL_NULL   = 3'd3;
	localparam logic [2:0] EL_BITS   = 3'd4;
	localparam logic [2:0] EL_RSASEQ = 3'd5;
	localparam logic [2:0] EL_MOD    = 3'd6;
	localparam logic [2:0] EL_EXP    = 3'd7;

	localparam logic [3:0] OID_LEN = 4'd9;
	localparam logic [3:0] OID_BAD = 4'd10;

	localparam logic [7:0] TAG_SEQ    = 8'h30;
	localparam logic [7:0] TAG_OID    = 8'h06;
	localparam logic [7:0] TAG_NULL   = 8'h05;
	localparam logic [7:0] TAG_BITS   = 8'h03;
	localparam logic [7:0] TAG_INT    = 8'h02;
	localparam logic [7:0] LONG_FORM  = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h7F;

	typedef enum logic [7:0] {
		PH_TAG      = 8'b0000_0001,
		PH_LEN      = 8'b0000_0010,
		PH_LEN_EXT  = 8'b0000_0100,
		PH_OID_BODY = 8'b0000_1000,
		PH_UNUSED   = 8'b0001_0000,
		PH_MOD_BODY = 8'b0010_0000,
		PH_EXP_BODY = 8'b0100_0000,
		PH_DONE     = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       value_valid;
		logic       value_which;
		logic [7:0] value_byte;
		logic       value_last;
	} result_t;

	typedef struct packed {
		phase_t               phase;
		logic [2:0]           elem;
		logic [LEN_W-1:0]     length_value;
		logic [LEN_CNT_W-1:0] length_left;
		logic [LEN_W-1:0]     content_left;
		logic [3:0]           oid_index;
		logic [2:0]           status;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:        PH_TAG,
		elem:         EL_OUTER,
		length_value: '0,
		length_left:  '0,
		content_left: '0,
		oid_index:    '0,
		status:       ST_BUSY
	};

	function automatic logic [7:0] elem_tag(input logic [2:0] elem);
		logic [7:0] tag;
		unique case (elem)
			EL_OUTER, EL_INNER, EL_RSASEQ: tag = TAG_SEQ;
			EL_OID:                        tag = TAG_OID;
			EL_NULL:                       tag = TAG_NULL;
			EL_BITS:                       tag = TAG_BITS;
			default:                       tag = TAG_INT;
		endcase
		return tag;
	endfunction

	// rsaEncryption 1.2.840.113549.1.1.1
	function automatic logic [7:0] oid_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = 8'h2a;
			4'd1:    b = 8'h86;
			4'd2:    b = 8'h48;
			4'd3:    b = 8'h86;
			4'd4:    b = 8'hf7;
			4'd5:    b = 8'h0d;
			4'd6:    b = 8'h01;
			4'd7:    b = 8'h01;
			4'd8:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== design/drpk_step.sv =====
// next-state and result logic for one byte of the der key stream
// depends on drpk_pkg
module drpk_step (
	input  drpk_pkg::parse_state_t cur,
	input  drpk_pkg::in_item_t     item,
	output drpk_pkg::parse_state_t nxt,
	output drpk_pkg::result_t      res
);
	import drpk_pkg::*;

	// a length field has been fully read for the current element
	function automatic parse_state_t length_done(input parse_state_t s,
	                                             input logic [LEN_W-1:0] len);
		parse_state_t r;
		logic         zero;
		r    = s;
		zero = (len == '0);
		unique case (s.elem)
			EL_OUTER, EL_INNER, EL_RSASEQ: begin
				r.elem  = s.elem + 3'd1;
				r.phase = PH_TAG;
			end
			EL_OID: begin
				if (zero) begin
					r.status = ST_OID;
				end else begin
					r.content_left = len;
					r.oid_index    = '0;
					r.phase        = PH_OID_BODY;
				end
			end
			EL_NULL: begin
				if (!zero) begin
					r.status = ST_NULL;
				end else begin
					r.elem  = EL_BITS;
					r.phase = PH_TAG;
				end
			end
			EL_BITS: begin
				if (zero) r.status = ST_BITS;
				else r.phase = PH_UNUSED;
			end
			EL_MOD: begin
				if (zero) begin
					r.elem  = EL_EXP;
					r.phase = PH_TAG;
				end else begin
					r.content_left = len;
					r.phase        = PH_MOD_BODY;
				end
			end
			default: begin
				if (zero) begin
					r.status = ST_DONE;
					r.phase  = PH_DONE;
				end else begin
					r.content_left = len;
					r.phase        = PH_EXP_BODY;
				end
			end
		endcase
		return r;
	endfunction

	parse_state_t         base;
	logic [7:0]           data;
	logic [6:0]           count;
	logic [LEN_W-1:0]     lv_shift;
	logic [LEN_CNT_W-1:0] len_left_dec;
	logic [LEN_W-1:0]     content_dec;

	always_comb begin
		data         = item.data_byte;
		base         = item.first_byte ? STATE_RESET : cur;
		count        = data[6:0] & COUNT_MASK[6:0];
		lv_shift     = LEN_W'({base.length_value, data});
		len_left_dec = (base.length_left != '0) ? base.length_left - LEN_CNT_W'(1)
		                                         : base.length_left;
		content_dec  = (base.content_left != '0) ? base.content_left - LEN_W'(1)
		                                          : base.content_left;
		nxt          = base;
		res          = '0;

		if (!item.first_byte && cur.status != ST_BUSY) begin
			// sticky: hold state, report status only
			nxt        = cur;
			res.status = cur.status;
		end else begin
			unique case (base.phase)
				PH_TAG: begin
					if (data != elem_tag(base.elem)) nxt.status = ST_TAG;
					else nxt.phase = PH_LEN;
				end
				PH_LEN: begin
					if ((data & LONG_FORM) != '0) begin
						if (count > 7'(MAX_LEN_BYTES)) begin
							nxt.status = ST_LEN;
						end else if (count == '0) begin
							nxt = length_done(base, '0);
						end else begin
							nxt.length_left  = count[LEN_CNT_W-1:0];
							nxt.length_value = '0;
							nxt.phase        = PH_LEN_EXT;
						end
					end else begin
						nxt = length_done(base, LEN_W'(data));
					end
				end
				PH_LEN_EXT: begin
					nxt.length_value = lv_shift;
					nxt.length_left  = len_left_dec;
					if (len_left_dec == '0) begin
						nxt = length_done(nxt, lv_shift);
					end
				end
				PH_OID_BODY: begin
					if (base.oid_index < OID_LEN && data == oid_byte(base.oid_index))
						nxt.oid_index = base.oid_index + 4'd1;
					else
						nxt.oid_index = OID_BAD;
					nxt.content_left = content_dec;
					if (content_dec == '0) begin
						if (nxt.oid_index == OID_LEN) begin
							nxt.elem  = EL_NULL;
							nxt.phase = PH_TAG;
						end else begin
							nxt.status = ST_OID;
						end
					end
				end
				PH_UNUSED: begin
					if (data != '0) begin
						nxt.status = ST_BITS;
					end else begin
						nxt.elem  = EL_RSASEQ;
						nxt.phase = PH_TAG;
					end
				end
				PH_MOD_BODY, PH_EXP_BODY: begin
					res.value_valid  = 1'b1;
					res.value_which  = (base.phase == PH_EXP_BODY);
					res.value_byte   = data;
					nxt.content_left = content_dec;
					if (content_dec == '0) begin
						res.value_last = 1'b1;
						if (base.phase == PH_MOD_BODY) begin
							nxt.elem  = EL_EXP;
							nxt.phase = PH_TAG;
						end else begin
							nxt.status = ST_DONE;
							nxt.phase  = PH_DONE;
						end
					end
				end
				default: begin
				end
			endcase

			if (nxt.status == ST_BUSY && item.last_byte) nxt.status = ST_EARLY;
			res.status = nxt.status;
		end
	end

endmodule

// ===== design/der_rsa_public_key_parser.sv =====
// der rsa public key parser: one result per input byte; each byte is held in the
// input stage register, and its result is then registered in the output register;
// one byte per cycle sustained throughput while out_ready stays high,
// set by the state update in drpk_step between input and result regs
// arst_n clears handshake valids and puts the parser at the outer sequence tag
// top level; depends on drpk_pkg and drpk_step
module der_rsa_public_key_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  drpk_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output drpk_pkg::result_t   out_data
);
	import drpk_pkg::*;

	in_item_t     item_s1;
	logic         valid_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res_nxt;
	result_t      out_q;
	logic         out_valid_q;
	logic         advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	drpk_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= STATE_RESET;
		end else begin
			valid_s1    <= (in_valid && in_ready) || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && !out_ready);
			if (advance) state_q <= state_nxt;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
		if (advance) out_q <= res_nxt;
	end

endmodule

// ===== tb/der_rsa_public_key_parser_test.sv =====
// testbench for der_rsa_public_key_parser: streams well-formed and damaged rsa keys
// byte by byte and checks every status/value result against a parser model built in here
// depends on drpk_pkg and der_rsa_public_key_parser
`timescale 1ns / 1ps

module der_rsa_public_key_parser_test;
	import drpk_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;
	// expected tag per layout element, element 0 in the low byte
	localparam logic [63:0] ELEM_TAGS = {TAG_INT, TAG_INT, TAG_SEQ, TAG_BITS,
		TAG_NULL, TAG_OID, TAG_SEQ, TAG_SEQ};
	localparam logic [71:0] RSA_OID = 72'h2a_86_48_86_f7_0d_01_01_01;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	in_item_t in_data;
	logic     out_valid;
	logic     out_ready;
	result_t  out_data;

	der_rsa_public_key_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// parser model state
	phase_t      prs_phase     = PH_TAG;
	logic [2:0]  prs_elem      = EL_OUTER;
	logic [63:0] prs_len       = '0;
	int          prs_len_left  = 0;
	logic [63:0] prs_body_left = '0;
	logic [3:0]  prs_oid_pos   = '0;
	logic [2:0]  prs_status    = ST_BUSY;

	result_t    parse_outcomes[$];
	logic [7:0] key_bytes[$];
	int         mark_oid_len, mark_null_len, mark_bits_len, mark_unused;
	int         mismatches   = 0;
	int         n_results    = 0;
	int         bytes_sent   = 0;
	int         hold_count;
	bit         hold_request = 1'b0;
	bit         tx_gaps_on   = 1'b1;
	bit         rx_stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void at_tag(logic [2:0] el);
		prs_phase = PH_TAG;
		prs_elem  = el;
	endfunction

	function automatic void close_length(logic [2:0] el, logic [63:0] len);
		case (el)
			EL_OUTER, EL_INNER, EL_RSASEQ: at_tag(el + 3'd1);
			EL_OID: begin
				if (len == 0) prs_status = ST_OID;
				else begin
					prs_body_left = len;
					prs_oid_pos   = '0;
					prs_phase     = PH_OID_BODY;
				end
			end
			EL_NULL: begin
				if (len != 0) prs_status = ST_NULL;
				else at_tag(EL_BITS);
			end
			EL_BITS: begin
				if (len == 0) prs_status = ST_BITS;
				else prs_phase = PH_UNUSED;
			end
			EL_MOD: begin
				if (len == 0) at_tag(EL_EXP);
				else begin
					prs_body_left = len;
					prs_phase     = PH_MOD_BODY;
				end
			end
			default: begin
				if (len == 0) begin
					prs_status = ST_DONE;
					prs_phase  = PH_DONE;
				end else begin
					prs_body_left = len;
					prs_phase     = PH_EXP_BODY;
				end
			end
		endcase
	endfunction

	// advance the parser model by one byte and return the result it produces
	function automatic result_t parse_byte(in_item_t it);
		result_t    r;
		logic [7:0] b;
		logic [6:0] cnt;
		r = '0;
		b = it.data_byte;
		if (it.first_byte) begin
			prs_phase     = PH_TAG;
			prs_elem      = EL_OUTER;
			prs_len       = '0;
			prs_len_left  = 0;
			prs_body_left = '0;
			prs_oid_pos   = '0;
			prs_status    = ST_BUSY;
		end else if (prs_status != ST_BUSY) begin
			r.status = prs_status;
			return r;
		end
		case (prs_phase)
			PH_TAG: begin
				if (b != ELEM_TAGS[8 * prs_elem +: 8]) prs_status = ST_TAG;
				else prs_phase = PH_LEN;
			end
			PH_LEN: begin
				if ((b & LONG_FORM) != 0) begin
					cnt = b[6:0];
					if (int'(cnt) > MAX_LEN_BYTES) prs_status = ST_LEN;
					else if (cnt == 0) close_length(prs_elem, '0);
					else begin
						prs_len_left = int'(cnt);
						prs_len      = '0;
						prs_phase    = PH_LEN_EXT;
					end
				end else
					close_length(prs_elem, {56'd0, b});
			end
			PH_LEN_EXT: begin
				prs_len = {prs_len[55:0], b};
				if (prs_len_left > 0) prs_len_left--;
				if (prs_len_left == 0) close_length(prs_elem, prs_len);
			end
			PH_OID_BODY: begin
				if (prs_oid_pos < OID_LEN && b == RSA_OID[8 * (8 - int'(prs_oid_pos)) +: 8])
					prs_oid_pos++;
				else
					prs_oid_pos = OID_BAD;
				if (prs_body_left > 0) prs_body_left--;
				if (prs_body_left == 0) begin
					if (prs_oid_pos == OID_LEN) at_tag(EL_NULL);
					else prs_status = ST_OID;
				end
			end
			PH_UNUSED: begin
				if (b != 8'h00) prs_status = ST_BITS;
				else at_tag(EL_RSASEQ);
			end
			PH_MOD_BODY, PH_EXP_BODY: begin
				r.value_valid = 1'b1;
				r.value_which = (prs_phase == PH_EXP_BODY);
				r.value_byte  = b;
				if (prs_body_left > 0) prs_body_left--;
				if (prs_body_left == 0) begin
					r.value_last = 1'b1;
					if (prs_phase == PH_MOD_BODY) at_tag(EL_EXP);
					else begin
						prs_status = ST_DONE;
						prs_phase  = PH_DONE;
					end
				end
			end
			default: ;
		endcase
		// an error found on this byte wins over the early end
		if (prs_status == ST_BUSY && it.last_byte) prs_status = ST_EARLY;
		r.status = prs_status;
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		mismatches++;
		$display("mismatch in %s at result %0d: got %0h, expected %0h",
			field, n_results, got, want);
	endtask

	// input transfers feed the model, output transfers are checked in order
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				parse_outcomes.insert(parse_outcomes.size(), parse_byte(in_data));
			if (out_valid && out_ready) begin
				if (parse_outcomes.size() == 0)
					report_mismatch("result with none pending", 1, 0);
				else begin
					want = parse_outcomes.pop_front();
					if (out_data.status != want.status)
						report_mismatch("status", int'(out_data.status),
							int'(want.status));
					if (out_data.value_valid != want.value_valid)
						report_mismatch("value_valid", int'(out_data.value_valid),
							int'(want.value_valid));
					if (out_data.value_which != want.value_which)
						report_mismatch("value_which", int'(out_data.value_which),
							int'(want.value_which));
					if (out_data.value_byte != want.value_byte)
						report_mismatch("value_byte", int'(out_data.value_byte),
							int'(want.value_byte));
					if (out_data.value_last != want.value_last)
						report_mismatch("value_last", int'(out_data.value_last),
							int'(want.value_last));
				end
				n_results++;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// result side: random stalls, plus one long hold when requested
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
				hold_request = 1'b0;
				out_ready <= 1'b1;
			end else if (rx_stalls_on && $urandom_range(0, 99) < 15) begin
				out_ready <= 1'b0;
				repeat (pick_gap() + 1) @(negedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		int       gap;
		in_item_t it;
		gap = tx_gaps_on ? pick_gap() : 0;
		it.data_byte  = b;
		it.first_byte = first;
		it.last_byte  = last;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [63:0] any_length();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v >> $urandom_range(0, 63);
	endfunction

	// append one byte to the key being built
	function automatic void add_key_byte(logic [7:0] b);
		key_bytes.insert(key_bytes.size(), b);
	endfunction

	// short form when it fits and chosen, else long form, sometimes with leading zeros
	function automatic void push_length(logic [63:0] len);
		int          need, n;
		logic [63:0] v;
		need = 0;
		v    = len;
		while (v != 0) begin
			need++;
			v = v >> 8;
		end
		if (len < 128 && $urandom_range(0, 2) != 0) begin
			add_key_byte(len[7:0]);
			return;
		end
		n = need;
		if ($urandom_range(0, 3) == 0) n = $urandom_range(need, MAX_LEN_BYTES);
		add_key_byte(LONG_FORM | 8'(n));
		for (int i = n - 1; i >= 0; i--) add_key_byte(8'(len >> (8 * i)));
	endfunction

	function automatic void build_key();
		int          mod_len, exp_len;
		logic [63:0] bits_len;
		mod_len  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 64))
		                                       : int'($urandom_range(0, 8));
		exp_len  = int'($urandom_range(0, 4));
		bits_len = any_length();
		if (bits_len == 0) bits_len = 1;
		key_bytes.delete();
		add_key_byte(TAG_SEQ);
		push_length(any_length());
		add_key_byte(TAG_SEQ);
		push_length(any_length());
		add_key_byte(TAG_OID);
		mark_oid_len = key_bytes.size();
		push_length(64'd9);
		for (int i = 8; i >= 0; i--) add_key_byte(RSA_OID[8 * i +: 8]);
		add_key_byte(TAG_NULL);
		mark_null_len = key_bytes.size();
		push_length(64'd0);
		add_key_byte(TAG_BITS);
		mark_bits_len = key_bytes.size();
		push_length(bits_len);
		mark_unused = key_bytes.size();
		add_key_byte(8'h00);
		add_key_byte(TAG_SEQ);
		push_length(any_length());
		add_key_byte(TAG_INT);
		push_length(64'(mod_len));
		repeat (mod_len) add_key_byte(8'($urandom));
		add_key_byte(TAG_INT);
		push_length(64'(exp_len));
		repeat (exp_len) add_key_byte(8'($urandom));
	endfunction

	// mostly clean keys; some get a random byte, a targeted fault or are cut short
	task automatic send_key();
		int   kind, cut;
		logic use_last;
		build_key();
		kind     = $urandom_range(0, 99);
		use_last = 1'($urandom_range(0, 1));
		if (kind >= 60 && kind < 75)
			key_bytes[$urandom_range(0, key_bytes.size() - 1)] = 8'($urandom);
		else if (kind >= 75 && kind < 88) begin
			case ($urandom_range(0, 4))
				0: key_bytes[mark_oid_len] = $urandom_range(0, 1) ? LONG_FORM
					: 8'($urandom_range(0, 12));
				1: key_bytes[mark_null_len] = 8'($urandom_range(1, 127));
				2: key_bytes[mark_bits_len] = $urandom_range(0, 1) ? LONG_FORM : 8'h00;
				3: key_bytes[mark_unused] = 8'($urandom_range(1, 255));
				default: key_bytes[mark_oid_len] = 8'($urandom_range(137, 255));
			endcase
		end else if (kind >= 88) begin
			cut = $urandom_range(1, key_bytes.size() - 1);
			while (key_bytes.size() > cut) void'(key_bytes.pop_back());
		end
		for (int i = 0; i < key_bytes.size(); i++)
			send_byte(key_bytes[i], i == 0, use_last && i == key_bytes.size() - 1);
		// trailing bytes after a finished key are ignored
		if (kind < 60 && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_noise(int count);
		repeat (count)
			send_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
	endtask

	task automatic test_directed();
		send_byte(8'hFF, 1'b1, 1'b1);          // wrong tag with last on the same byte
		send_byte(8'h00, 1'b0, 1'b0);          // error is sticky
		send_byte(TAG_SEQ, 1'b1, 1'b0);
		send_byte(8'h89, 1'b0, 1'b0);          // too many length bytes
		send_byte(TAG_SEQ, 1'b1, 1'b1);        // data ends early
		// minimal key: long form zero lengths, empty modulus, one exponent byte
		send_byte(TAG_SEQ, 1'b1, 1'b0);
		send_byte(LONG_FORM, 1'b0, 1'b0);
		send_byte(TAG_SEQ, 1'b0, 1'b0);
		send_byte(LONG_FORM, 1'b0, 1'b0);
		send_byte(TAG_OID, 1'b0, 1'b0);
		send_byte(8'h09, 1'b0, 1'b0);
		for (int i = 8; i >= 0; i--) send_byte(RSA_OID[8 * i +: 8], 1'b0, 1'b0);
		send_byte(TAG_NULL, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(TAG_BITS, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(TAG_SEQ, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(TAG_INT, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(TAG_INT, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);          // completes; last does not override
		send_byte(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_back_to_back();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		repeat (4) send_key();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	task automatic test_random_keys(int target);
		target += bytes_sent;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 6));
			else send_key();
		end
	endtask

	// results held back long enough that the block fills and stalls its input
	task automatic test_full_stall();
		tx_gaps_on   = 1'b0;
		hold_request = 1'b1;
		repeat (2) send_key();
		tx_gaps_on   = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_key();
		go_idle();
		while (parse_outcomes.size() != 0) @(posedge clk);
		repeat (2) send_key();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_back_to_back();
		test_random_keys(300);
		test_full_stall();
		test_drain_pause();

		go_idle();
		while (parse_outcomes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (parse_outcomes.size() != 0)
			report_mismatch("results missing", 0, parse_outcomes.size());
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
